>>> design/assert_macros.svh
// Assertion macros shared by the tokenizer RTL.
// Depends on: nothing; the user module must have aclk and aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational property, checked at every rising clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Antecedent this cycle implies consequent next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/ltc_pkg.sv
// Package for the line tokenizer with checksum: beat types, result kinds, byte codes.
// Depends on: nothing.
`default_nettype none

package ltc_pkg;

    localparam int SUM_W  = 64;
    localparam int BYTE_W = 8;
    localparam int MASK_W = 4;   // one bit per result kind

    localparam logic [BYTE_W-1:0] BYTE_LF    = 8'd10;
    localparam logic [BYTE_W-1:0] BYTE_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] BYTE_HASH  = 8'd35;
    localparam logic [BYTE_W-1:0] BYTE_SPACE = 8'd32;

    // checksum * 31 = (checksum << HASH_SHIFT) - checksum
    localparam int HASH_SHIFT = 5;

    typedef enum logic [1:0] {
        KIND_TOKEN_BYTE = 2'd0,
        KIND_END_TOKEN  = 2'd1,
        KIND_END_LINE   = 2'd2,
        KIND_END_INPUT  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              end_of_input;
    } ltc_in_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] token_byte;
        logic [SUM_W-1:0]  running_sum;
        logic              last;
    } ltc_out_t;

    // All results of one input beat; mask bit k set means a result of kind k.
    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic [BYTE_W-1:0] token_byte;
        logic [SUM_W-1:0]  running_sum;
    } ltc_bundle_t;

endpackage

`default_nettype wire

>>> design/ltc_parse.sv
// Tokenizer state and per-beat step: checksum update, line/token flags, result mask.
// Depends on: ltc_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ltc_parse import ltc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step_en,
    input  wire ltc_in_t     item,
    output ltc_bundle_t      bundle
);

    logic [SUM_W-1:0] checksum_reg, checksum_next;
    logic line_nonempty_reg, line_nonempty_next;
    logic comment_line_reg, comment_line_next;
    logic inside_token_reg, inside_token_next;
    logic line_has_token_reg, line_has_token_next;

    logic [SUM_W-1:0] sum_hashed;
    logic             is_eol;

    assign sum_hashed = (checksum_reg << HASH_SHIFT) - checksum_reg
                        + {{(SUM_W-BYTE_W){1'b0}}, item.in_byte};
    assign is_eol = (item.in_byte == BYTE_LF) || (item.in_byte == BYTE_CR);

    always_comb begin
        checksum_next       = checksum_reg;
        line_nonempty_next  = line_nonempty_reg;
        comment_line_next   = comment_line_reg;
        inside_token_next   = inside_token_reg;
        line_has_token_next = line_has_token_reg;
        bundle.mask         = '0;
        bundle.token_byte   = '0;
        bundle.running_sum  = checksum_reg;

        if (item.end_of_input || is_eol) begin
            bundle.mask[KIND_END_TOKEN] = inside_token_reg;
            bundle.mask[KIND_END_LINE]  = line_has_token_reg;
            bundle.mask[KIND_END_INPUT] = item.end_of_input;
            line_nonempty_next  = 1'b0;
            comment_line_next   = 1'b0;
            inside_token_next   = 1'b0;
            line_has_token_next = 1'b0;
        end else begin
            line_nonempty_next = 1'b1;
            if (!line_nonempty_reg) begin
                comment_line_next = (item.in_byte == BYTE_HASH);
            end
            if (!comment_line_next) begin
                if (item.in_byte <= BYTE_SPACE) begin
                    bundle.mask[KIND_END_TOKEN] = inside_token_reg;
                    inside_token_next = 1'b0;
                end else begin
                    bundle.mask[KIND_TOKEN_BYTE] = 1'b1;
                    bundle.token_byte   = item.in_byte;
                    inside_token_next   = 1'b1;
                    line_has_token_next = 1'b1;
                end
            end
        end

        if (!item.end_of_input) begin
            checksum_next      = sum_hashed;
            bundle.running_sum = sum_hashed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            checksum_reg       <= '0;
            line_nonempty_reg  <= 1'b0;
            comment_line_reg   <= 1'b0;
            inside_token_reg   <= 1'b0;
            line_has_token_reg <= 1'b0;
        end else if (step_en) begin
            checksum_reg       <= checksum_next;
            line_nonempty_reg  <= line_nonempty_next;
            comment_line_reg   <= comment_line_next;
            inside_token_reg   <= inside_token_next;
            line_has_token_reg <= line_has_token_next;
        end
    end

    `ASSERT_ALWAYS(a_token_implies_line, !inside_token_reg || line_has_token_reg, "open token without line token flag")
    `ASSERT_ALWAYS(a_comment_no_token, !comment_line_reg || !line_has_token_reg, "token emitted on a comment line")

endmodule

`default_nettype wire

>>> design/ltc_out_seq.sv
// Result register: holds one beat's result mask and sends its results in kind order.
// Depends on: ltc_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ltc_out_seq import ltc_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         load,
    input  wire ltc_bundle_t  bundle,
    output logic              out_free,
    output logic              m_valid,
    input  wire logic         m_ready,
    output ltc_out_t          m_payload
);

    logic [MASK_W-1:0] mask_reg, mask_next;
    logic [BYTE_W-1:0] token_byte_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [MASK_W-1:0] rest_mask;
    kind_t             kind_cur;

    assign rest_mask = mask_reg & (mask_reg - MASK_W'(1));
    assign m_valid   = (mask_reg != '0);
    assign out_free  = !m_valid || (m_ready && (rest_mask == '0));

    always_comb begin
        if (mask_reg[KIND_TOKEN_BYTE]) begin
            kind_cur = KIND_TOKEN_BYTE;
        end else if (mask_reg[KIND_END_TOKEN]) begin
            kind_cur = KIND_END_TOKEN;
        end else if (mask_reg[KIND_END_LINE]) begin
            kind_cur = KIND_END_LINE;
        end else begin
            kind_cur = KIND_END_INPUT;
        end
    end

    always_comb begin
        m_payload.kind        = kind_cur;
        m_payload.token_byte  = token_byte_reg;
        m_payload.running_sum = sum_reg;
        m_payload.last        = (rest_mask == '0);
    end

    always_comb begin
        mask_next = mask_reg;
        if (load) begin
            mask_next = bundle.mask;
        end else if (m_valid && m_ready) begin
            mask_next = rest_mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            token_byte_reg <= bundle.token_byte;
            sum_reg        <= bundle.running_sum;
        end
    end

    `ASSERT_ALWAYS(a_byte_alone, !mask_reg[KIND_TOKEN_BYTE] || (mask_reg[MASK_W-1:1] == '0), "token byte shares a beat")
    `ASSERT_ALWAYS(a_load_when_free, !load || out_free, "result register overwritten")
    `ASSERT_NEXT(a_more_follow, m_valid && m_ready && !m_payload.last, m_valid, "result of a beat lost")

endmodule

`default_nettype wire

>>> design/line_tokenizer_with_checksum_core.sv
// Top level of the line tokenizer with 64-bit checksum: input register, step, result register.
// Depends on: ltc_pkg, ltc_parse, ltc_out_seq, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// One byte (or end-of-input mark) per s_ beat; results leave on m_ one per beat in order
// token byte, end of token, end of line, end of input. An accepted beat is registered in the
// input register, then stepped and loaded into the result register. Throughput is one input
// beat per cycle while each beat yields at most one result and m_ready is high. A beat with
// more (a line end up to two, end of input up to three) holds the result register, which
// sends one result per cycle. Beats that yield no result pass without occupying the output.

module line_tokenizer_with_checksum_core import ltc_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire ltc_in_t   s_payload,
    output logic           m_valid,
    input  wire logic      m_ready,
    output ltc_out_t       m_payload
);

    logic        in_valid_reg, in_valid_next;
    ltc_in_t     in_item_reg;
    logic        out_free;
    logic        advance;
    ltc_bundle_t bundle;

    assign advance = in_valid_reg && out_free;
    assign s_ready = !in_valid_reg || out_free;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_payload;
        end
    end

    ltc_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .bundle  (bundle)
    );

    ltc_out_seq u_out_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance),
        .bundle    (bundle),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    `ASSERT_NEXT(a_held_item, in_valid_reg && !advance, in_valid_reg, "buffered beat dropped")

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking bench for line_tokenizer_with_checksum_core: a directed table, then random text.
// Every result is checked against a behavioral tokenizer and checksum or a typed directed row.
// Depends on: ltc_pkg and the line_tokenizer_with_checksum_core RTL.
module tb_top;
    import ltc_pkg::*;

    localparam logic [SUM_W-1:0] HASH_MULT = 64'd31;
    localparam int RANDOM_ITEMS    = 250;
    localparam int HOLD_OFF_AT     = 30;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 20;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int N_DIRECTED      = 20;

    typedef struct packed {
        ltc_in_t  beat;
        logic     typed;
        ltc_out_t want;
    } stim_row_t;

    // Directed rows; a set typed bit means the expected result is given here.
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{'{8'h00, 1'b1}, 1'b1, '{KIND_END_INPUT,  8'h00, 64'd0,    1'b1}},
        '{'{8'hFF, 1'b0}, 1'b1, '{KIND_TOKEN_BYTE, 8'hFF, 64'd255,  1'b1}},
        '{'{8'h00, 1'b0}, 1'b1, '{KIND_END_TOKEN,  8'h00, 64'd7905, 1'b1}},
        '{'{8'h21, 1'b0}, 1'b0, '0},
        '{'{8'h20, 1'b0}, 1'b0, '0},
        '{'{8'h0A, 1'b0}, 1'b0, '0},
        '{'{8'h23, 1'b0}, 1'b0, '0},
        '{'{8'h78, 1'b0}, 1'b0, '0},
        '{'{8'h20, 1'b0}, 1'b0, '0},
        '{'{8'h0A, 1'b0}, 1'b0, '0},
        '{'{8'h20, 1'b0}, 1'b0, '0},
        '{'{8'h0D, 1'b0}, 1'b0, '0},
        '{'{8'h0A, 1'b0}, 1'b0, '0},
        '{'{8'h80, 1'b0}, 1'b0, '0},
        '{'{8'h23, 1'b0}, 1'b0, '0},
        '{'{8'h7F, 1'b0}, 1'b0, '0},
        '{'{8'h0D, 1'b0}, 1'b0, '0},
        '{'{8'h71, 1'b0}, 1'b0, '0},
        '{'{8'hFF, 1'b1}, 1'b0, '0},
        '{'{8'hAA, 1'b1}, 1'b0, '0}
    };

    logic     aclk      = 1'b0;
    logic     aresetn   = 1'b0;
    logic     s_valid   = 1'b0;
    ltc_in_t  s_payload = '0;
    logic     m_ready   = 1'b0;
    logic     s_ready;
    logic     m_valid;
    ltc_out_t m_payload;

    // predictor state
    logic [SUM_W-1:0] sum_q       = '0;
    bit               line_started = 1'b0;
    bit               in_comment   = 1'b0;
    bit               token_open   = 1'b0;
    bit               line_tokens  = 1'b0;

    ltc_out_t expected_beats[$];
    int       errors       = 0;
    int       results_seen = 0;

    line_tokenizer_with_checksum_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic ltc_out_t make_result(kind_t k, logic [BYTE_W-1:0] tok);
        ltc_out_t r;
        r.kind        = k;
        r.token_byte  = tok;
        r.running_sum = sum_q;
        r.last        = 1'b0;
        return r;
    endfunction

    task automatic tokenize_beat(input ltc_in_t b, input bit record);
        ltc_out_t staged[3];
        int       n;
        bit       close;
        n = 0;
        close = b.end_of_input;
        if (!b.end_of_input) begin
            sum_q = sum_q * HASH_MULT + {56'd0, b.in_byte};
            if (b.in_byte == BYTE_LF || b.in_byte == BYTE_CR) begin
                close = 1'b1;
            end else begin
                if (!line_started) begin
                    line_started = 1'b1;
                    in_comment   = (b.in_byte == BYTE_HASH);
                end
                if (!in_comment) begin
                    if (b.in_byte <= BYTE_SPACE) begin
                        if (token_open) begin
                            staged[n] = make_result(KIND_END_TOKEN, 8'h00);
                            n++;
                            token_open = 1'b0;
                        end
                    end else begin
                        staged[n] = make_result(KIND_TOKEN_BYTE, b.in_byte);
                        n++;
                        token_open  = 1'b1;
                        line_tokens = 1'b1;
                    end
                end
            end
        end
        if (close) begin
            if (token_open) begin
                staged[n] = make_result(KIND_END_TOKEN, 8'h00);
                n++;
            end
            if (line_tokens) begin
                staged[n] = make_result(KIND_END_LINE, 8'h00);
                n++;
            end
            line_started = 1'b0;
            in_comment   = 1'b0;
            token_open   = 1'b0;
            line_tokens  = 1'b0;
        end
        if (b.end_of_input) begin
            staged[n] = make_result(KIND_END_INPUT, 8'h00);
            n++;
        end
        if (record) begin
            for (int i = 0; i < n; i++) begin
                staged[i].last = (i == n - 1);
                expected_beats = {expected_beats, staged[i]};
            end
        end
    endtask

    task automatic check_result(input ltc_out_t got);
        ltc_out_t want;
        if (expected_beats.size() == 0) begin
            $error("unexpected result beat: kind %0d token_byte %h running_sum %h last %0d",
                   got.kind, got.token_byte, got.running_sum, got.last);
            errors++;
        end else begin
            want = expected_beats.pop_front();
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                errors++;
            end
            if (got.token_byte !== want.token_byte) begin
                $error("token_byte: expected %h, actual %h", want.token_byte, got.token_byte);
                errors++;
            end
            if (got.running_sum !== want.running_sum) begin
                $error("running_sum: expected %h, actual %h",
                       want.running_sum, got.running_sum);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                errors++;
            end
        end
    endtask

    task automatic send_beat(input ltc_in_t b, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 11);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    // result side: random stall per beat, bursts without stalls, one long hold-off
    initial begin
        int stall;
        bit sink_burst;
        sink_burst = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (results_seen % 32 == 0) begin
                sink_burst = ($urandom_range(0, 3) == 0);
            end
            stall = sink_burst ? 0 : $urandom_range(0, 11);
            if (results_seen == HOLD_OFF_AT) begin
                stall = HOLD_OFF_CYCLES;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            check_result(m_payload);
            results_seen++;
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("line_tokenizer_with_checksum_core regression: fail");
        $finish;
    end

    initial begin
        ltc_in_t beat;
        int      sel;
        bit      send_burst;
        bit      fresh_line;
        send_burst = 1'b0;
        fresh_line = 1'b1;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_beat(DIRECTED[i].beat, 1'b0);
            tokenize_beat(DIRECTED[i].beat, !DIRECTED[i].typed);
            if (DIRECTED[i].typed) begin
                expected_beats = {expected_beats, DIRECTED[i].want};
            end
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 32 == 0) begin
                send_burst = ($urandom_range(0, 3) == 0);
            end
            sel  = $urandom_range(0, 99);
            beat = '0;
            if (fresh_line && sel < 20) begin
                beat.in_byte = BYTE_HASH;
            end else if (sel < 45) begin
                beat.in_byte = 8'($urandom_range(33, 126));
            end else if (sel < 60) begin
                beat.in_byte = (sel < 52) ? BYTE_SPACE : 8'($urandom_range(0, 32));
            end else if (sel < 72) begin
                beat.in_byte = (sel % 2 == 0) ? BYTE_LF : BYTE_CR;
            end else if (sel < 82) begin
                beat.in_byte = 8'($urandom_range(128, 255));
            end else if (sel < 97) begin
                beat.in_byte = 8'($urandom_range(0, 255));
            end else begin
                beat.in_byte      = 8'($urandom_range(0, 255));
                beat.end_of_input = 1'b1;
            end
            fresh_line = beat.end_of_input || beat.in_byte == BYTE_LF
                         || beat.in_byte == BYTE_CR;
            send_beat(beat, send_burst);
            tokenize_beat(beat, 1'b1);
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0 && expected_beats.size() == 0) begin
            $display("line_tokenizer_with_checksum_core regression: pass");
        end else begin
            $display("line_tokenizer_with_checksum_core regression: fail");
        end
        $finish;
    end

endmodule
